@@ src/rhd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhd_pkg
// types and constants shared by the cartridge header decoder files
// ----------------------------------------------------------------------------
package rhd_pkg;

	localparam int unsigned HDR_LEN = 16;
	localparam int unsigned SLOT_W  = 4;
	localparam int unsigned CFG_ADDR_W = 3;

	// register index is paddr[2] (byte address 4*i)
	localparam logic REG_FILE_LENGTH = 1'b0;

	localparam logic [SLOT_W-1:0] LAST_SLOT = 4'd15;

	localparam logic [3:0][7:0] SIGNATURE = {8'h1A, 8'h53, 8'h45, 8'h4E};

	localparam logic [7:0] B7_FMT_MASK = 8'h0C;
	localparam logic [7:0] B7_FMT_NES2 = 8'h08;
	localparam logic [3:0] EXP_MSB     = 4'hF;
	localparam logic [3:0] PRG_UNIT_LOG = 4'd14;
	localparam logic [3:0] CHR_UNIT_LOG = 4'd13;

	localparam logic [13:0] CHR_RAM_DEFAULT = 14'd8192;
	localparam logic [20:0] PRG_RAM_DEFAULT = 21'd8192;

	typedef enum logic [1:0] {
		FMT_ARCHAIC = 2'd0,
		FMT_INES    = 2'd1,
		FMT_NES2    = 2'd2
	} hdr_fmt_t;

	typedef logic [HDR_LEN-1:0][7:0] hdr_bytes_t;

	typedef struct packed {
		logic        status;
		logic [1:0]  header_format;
		logic [21:0] program_rom_bytes;
		logic [20:0] character_rom_bytes;
		logic [13:0] character_ram_bytes;
		logic [20:0] program_ram_bytes;
		logic [7:0]  mapper_number;
		logic [3:0]  cart_flags;
		logic        console_kind;
		logic        tv_system;
	} result_t;

endpackage
`default_nettype wire

@@ src/rhd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhd_if
// valid/ready channels for header bytes and decoded results
// ----------------------------------------------------------------------------
interface rhd_hdr_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;

	modport source (output valid, output header_byte, input ready);
	modport sink   (input valid, input header_byte, output ready);
endinterface

interface rhd_res_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [1:0]  header_format;
	logic [21:0] program_rom_bytes;
	logic [20:0] character_rom_bytes;
	logic [13:0] character_ram_bytes;
	logic [20:0] program_ram_bytes;
	logic [7:0]  mapper_number;
	logic [3:0]  cart_flags;
	logic        console_kind;
	logic        tv_system;

	modport source (
		output valid, output status, output header_format, output program_rom_bytes,
		output character_rom_bytes, output character_ram_bytes,
		output program_ram_bytes, output mapper_number, output cart_flags,
		output console_kind, output tv_system, input ready
	);
	modport sink (
		input valid, input status, input header_format, input program_rom_bytes,
		input character_rom_bytes, input character_ram_bytes,
		input program_ram_bytes, input mapper_number, input cart_flags,
		input console_kind, input tv_system, output ready
	);
endinterface
`default_nettype wire

@@ src/rhd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhd_decode
// decodes a complete 16-byte header into one result
// ----------------------------------------------------------------------------
module rhd_decode (
	input  wire rhd_pkg::hdr_bytes_t hdr,
	input  wire logic [31:0]      file_length,
	output rhd_pkg::result_t      res
);
	import rhd_pkg::*;

	typedef logic [34:0] size_t;

	// sizes at or above 2^32 never fit the file, so clamp well above that
	localparam size_t SIZE_BIG = size_t'(1) << 34;

	function automatic size_t section_size(input logic [7:0] lsb, input logic [3:0] msb,
		input logic [3:0] unit_log);
		logic [5:0] e;
		logic [2:0] m;
		size_t      r;
		e = lsb[7:2];
		m = {lsb[1:0], 1'b1};
		if (msb == EXP_MSB) begin
			if (e[5]) r = SIZE_BIG;
			else r = {32'd0, m} << e[4:0];
		end else begin
			r = {23'd0, msb, lsb} << unit_log;
		end
		return r;
	endfunction

	size_t       prg_size;
	size_t       chr_size;
	logic [35:0] total;
	logic        sig_ok;
	logic        nes2;
	logic        archaic;
	hdr_fmt_t    fmt;

	always_comb begin
		sig_ok   = (hdr[3:0] == SIGNATURE);
		prg_size = section_size(hdr[4], hdr[9][3:0], PRG_UNIT_LOG);
		chr_size = section_size(hdr[5], hdr[9][7:4], CHR_UNIT_LOG);
		total    = {1'b0, prg_size} + {1'b0, chr_size} + 36'(HDR_LEN);
		nes2     = ((hdr[7] & B7_FMT_MASK) == B7_FMT_NES2) && (total <= {4'd0, file_length});
		archaic  = |(hdr[12] | hdr[13] | hdr[14] | hdr[15]);

		priority if (nes2) fmt = FMT_NES2;
		else if (archaic) fmt = FMT_ARCHAIC;
		else fmt = FMT_INES;

		res = '0;
		if (!sig_ok) begin
			res.status = 1'b1;
		end else begin
			res.header_format       = fmt;
			res.program_rom_bytes   = {hdr[4], 14'd0};
			res.character_rom_bytes = {hdr[5], 13'd0};
			res.character_ram_bytes = (hdr[5] == 8'd0) ? CHR_RAM_DEFAULT : 14'd0;
			res.cart_flags          = hdr[6][3:0];
			if (fmt == FMT_ARCHAIC) begin
				res.mapper_number = {4'd0, hdr[6][7:4]};
			end else begin
				res.program_ram_bytes = (hdr[8] == 8'd0) ? PRG_RAM_DEFAULT : {hdr[8], 13'd0};
				res.mapper_number     = {hdr[7][7:4], hdr[6][7:4]};
				res.console_kind      = hdr[7][0];
				res.tv_system         = hdr[9][0];
			end
		end
	end

endmodule
`default_nettype wire

@@ src/rom_header_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rom_header_decoder
// collects 16 cartridge header bytes and emits one decoded result per header
// ----------------------------------------------------------------------------
// channel   dir  handshake          carries
// hdr       in   valid/ready        header_byte, one per transaction
// res       out  valid/ready        decoded header, one per 16 input transactions
// apb       in   psel/penable       file_length at address 0
//
// one header byte per cycle; bytes go straight into the header register file
// the decode runs the cycle after the sixteenth byte and loads the result register once it is free
// input stalls only while a finished header waits and the result register is held
// reset clears the byte counter, the pending flag, the result valid and file_length
// ----------------------------------------------------------------------------
module rom_header_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	rhd_hdr_if.sink                            hdr,
	rhd_res_if.source                          res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rhd_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready
);
	import rhd_pkg::*;

	logic [SLOT_W-1:0] byte_count_q;
	hdr_bytes_t        header_q;
	logic              last_s1;
	logic [31:0]       file_length_q;
	logic              res_valid_q;
	result_t           res_q;
	result_t           dec;
	logic              hdr_acc;
	logic              res_load;
	logic              cfg_wr;
	logic              reg_sel;

	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready & (reg_sel == REG_FILE_LENGTH);
	assign prdata  = (reg_sel == REG_FILE_LENGTH) ? file_length_q : 32'd0;

	assign res_load  = last_s1 & (~res_valid_q | res.ready);
	assign hdr.ready = ~last_s1 | res_load;
	assign hdr_acc   = hdr.valid & hdr.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_wr) begin
			file_length_q <= pwdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			last_s1      <= 1'b0;
		end else begin
			if (hdr_acc) byte_count_q <= byte_count_q + SLOT_W'(1);
			if (hdr_acc && byte_count_q == LAST_SLOT) last_s1 <= 1'b1;
			else if (res_load) last_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_acc) header_q[byte_count_q] <= hdr.header_byte;
	end

	rhd_decode u_decode (
		.hdr         (header_q),
		.file_length (file_length_q),
		.res         (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= dec;
	end

	assign res.valid               = res_valid_q;
	assign res.status              = res_q.status;
	assign res.header_format       = res_q.header_format;
	assign res.program_rom_bytes   = res_q.program_rom_bytes;
	assign res.character_rom_bytes = res_q.character_rom_bytes;
	assign res.character_ram_bytes = res_q.character_ram_bytes;
	assign res.program_ram_bytes   = res_q.program_ram_bytes;
	assign res.mapper_number       = res_q.mapper_number;
	assign res.cart_flags          = res_q.cart_flags;
	assign res.console_kind        = res_q.console_kind;
	assign res.tv_system           = res_q.tv_system;

	a_pending_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(last_s1 && !res_load) |-> !hdr.ready)
		else $error("header byte accepted while a finished header waits");

	a_last_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_acc && byte_count_q == LAST_SLOT) |=> last_s1)
		else $error("sixteenth byte did not start a decode");

	a_result_from_pending: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(last_s1))
		else $error("result appeared without a complete header");

	a_mismatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status) |->
		(res_q.header_format == FMT_ARCHAIC && res_q.mapper_number == 8'd0 &&
		 res_q.program_rom_bytes == 22'd0 && res_q.character_ram_bytes == 14'd0))
		else $error("signature mismatch result carries nonzero fields");

endmodule
`default_nettype wire
